### sv/keyed_value_table_top_macros.svh
// assertion helpers for the key/value table
// both sample on clk and are switched off while arst_n is low
`ifndef KEYED_VALUE_TABLE_TOP_MACROS_SVH
`define KEYED_VALUE_TABLE_TOP_MACROS_SVH

// consequent holds in the same cycle as the antecedent
`define KVT_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("kvt check failed");

// consequent holds in the cycle after the antecedent
`define KVT_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("kvt check failed");

`endif

### sv/kvt_pkg.sv
`default_nettype none

package kvt_pkg;

	// default sizes
	localparam int TABLE_DEPTH_DEF = 32;
	localparam int KEY_BITS_DEF    = 16;
	localparam int VALUE_BITS_DEF  = 32;
	localparam int COUNT_BITS_DEF  = $clog2(TABLE_DEPTH_DEF + 1);

	// command codes
	localparam logic [2:0] CMD_INSERT = 3'd0;
	localparam logic [2:0] CMD_ERASE  = 3'd1;
	localparam logic [2:0] CMD_CLEAR  = 3'd2;
	localparam logic [2:0] CMD_LOOKUP = 3'd3;
	localparam logic [2:0] CMD_COUNT  = 3'd4;

endpackage

`default_nettype wire

### sv/kvt_if.sv
`default_nettype none

// command channel
interface kvt_req_if #(
	parameter int KEY_BITS   = kvt_pkg::KEY_BITS_DEF,
	parameter int VALUE_BITS = kvt_pkg::VALUE_BITS_DEF
);
	logic                  valid;
	logic                  ready;
	logic [2:0]            cmd;
	logic [KEY_BITS-1:0]   key_in;
	logic [VALUE_BITS-1:0] value_in;

	modport source (output valid, cmd, key_in, value_in, input ready);
	modport sink   (input valid, cmd, key_in, value_in, output ready);
endinterface

// result channel
interface kvt_rsp_if #(
	parameter int VALUE_BITS = kvt_pkg::VALUE_BITS_DEF,
	parameter int COUNT_BITS = kvt_pkg::COUNT_BITS_DEF
);
	logic                  valid;
	logic                  ready;
	logic                  found;
	logic [VALUE_BITS-1:0] value_out;
	logic [COUNT_BITS-1:0] match_count;
	logic [COUNT_BITS-1:0] fill_level;
	logic                  error;

	modport source (output valid, found, value_out, match_count, fill_level, error,
		input ready);
	modport sink   (input valid, found, value_out, match_count, fill_level, error,
		output ready);
endinterface

`default_nettype wire

### sv/kvt_ram.sv
`default_nettype none

// simple dual-port ram, one write and one registered read
module kvt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [ADDR_BITS-1:0] waddr,
	input  logic [WIDTH-1:0]     wdata,
	input  logic                 re,
	input  logic [ADDR_BITS-1:0] raddr,
	output logic [WIDTH-1:0]     rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

### sv/keyed_value_table_top.sv
// keyed_value_table_top: fixed-capacity key/value table, linear search
//
// req channel (valid/ready) carries cmd, key_in and value_in; rsp channel
// (valid/ready) returns found, value_out, match_count, fill_level and error,
// one result item per command item, in order.
// pairs sit packed in slots 0 to fill-1 of a single ram (key and value side
// by side). insert, erase, lookup and count read every live slot once, one
// slot per cycle through the ram's registered read port; clear and unknown
// commands skip the scan.
// with n entries held, a scanning item goes from acceptance through n slot
// reads, the registered ram read and compare of the last slot, a commit in
// the done state (held while rsp is busy) and a return to idle before the
// next acceptance; a non-scanning item goes from idle straight to done. the
// result is registered on commit. the ram read port scans one slot a cycle.
// erase copies the last slot, captured during the scan, into the hole.
// reset empties the table at once (fill to zero); stale ram contents are
// never read, so no clearing pass is needed and req.ready is high right away.
// results wait in an output register; the next item is taken while one
// waits, but a finished item holds in its commit cycle until rsp is free.
`default_nettype none
`include "keyed_value_table_top_macros.svh"

module keyed_value_table_top #(
	parameter int TABLE_DEPTH = kvt_pkg::TABLE_DEPTH_DEF,
	parameter int KEY_BITS    = kvt_pkg::KEY_BITS_DEF,
	parameter int VALUE_BITS  = kvt_pkg::VALUE_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	kvt_req_if.sink   req,
	kvt_rsp_if.source rsp
);
	import kvt_pkg::*;

	localparam int ADDR_BITS  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int COUNT_BITS = $clog2(TABLE_DEPTH + 1);
	localparam int ENTRY_BITS = KEY_BITS + VALUE_BITS;
	localparam logic [COUNT_BITS-1:0] FULL_LEVEL = COUNT_BITS'(TABLE_DEPTH);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	// control
	state_t                state_q;
	logic [COUNT_BITS-1:0] fill_q;
	logic                  issue_done_q;
	logic                  rd_vld_s1;
	logic                  rsp_valid_q;

	// item and scan results
	logic [2:0]            cmd_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [VALUE_BITS-1:0] val_q;
	logic [ADDR_BITS-1:0]  issue_idx_q;
	logic [ADDR_BITS-1:0]  rd_idx_s1;
	logic                  hit_q;
	logic [ADDR_BITS-1:0]  slot_q;
	logic [VALUE_BITS-1:0] hit_val_q;
	logic [COUNT_BITS-1:0] count_q;
	logic [ENTRY_BITS-1:0] last_q;

	// result register
	logic                  found_q;
	logic [VALUE_BITS-1:0] value_out_q;
	logic [COUNT_BITS-1:0] match_count_q;
	logic [COUNT_BITS-1:0] level_q;
	logic                  error_q;

	logic                  accept;
	logic                  scan_cmd;
	logic                  commit;
	logic                  rd_en;
	logic [ADDR_BITS-1:0]  last_idx;
	logic [ENTRY_BITS-1:0] rd_data;
	logic [KEY_BITS-1:0]   rd_key;
	logic [VALUE_BITS-1:0] rd_val;

	logic                  nx_found;
	logic [VALUE_BITS-1:0] nx_value;
	logic [COUNT_BITS-1:0] nx_count;
	logic                  nx_err;
	logic [COUNT_BITS-1:0] nx_fill;
	logic                  mem_we;
	logic [ADDR_BITS-1:0]  mem_waddr;
	logic [ENTRY_BITS-1:0] mem_wdata;

	assign req.ready = (state_q == ST_IDLE);
	assign accept    = req.valid && req.ready;
	assign scan_cmd  = (req.cmd == CMD_INSERT) || (req.cmd == CMD_ERASE) ||
		(req.cmd == CMD_LOOKUP) || (req.cmd == CMD_COUNT);

	// a finished item leaves once the result register is free or draining
	assign commit = (state_q == ST_DONE) && (!rsp_valid_q || rsp.ready);

	// scan: issue slot addresses 0..fill-1, compare in the next cycle
	assign last_idx = ADDR_BITS'(fill_q - 1'b1);
	assign rd_en    = (state_q == ST_SCAN) && !issue_done_q;
	assign rd_key   = rd_data[ENTRY_BITS-1 -: KEY_BITS];
	assign rd_val   = rd_data[VALUE_BITS-1:0];

	// writes only happen on commit, and a read can start only after idle has
	// accepted a new item and scan has begun, so the ram never sees a read of
	// a slot being written in the same cycle
	kvt_ram #(
		.WIDTH (ENTRY_BITS),
		.DEPTH (TABLE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (rd_en),
		.raddr (issue_idx_q),
		.rdata (rd_data)
	);

	// outcome of the item once the scan is over
	always_comb begin
		nx_found  = 1'b0;
		nx_value  = '0;
		nx_count  = '0;
		nx_err    = 1'b0;
		nx_fill   = fill_q;
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = '0;
		unique case (cmd_q)
			CMD_INSERT: begin
				if (hit_q || (fill_q == FULL_LEVEL)) begin
					nx_err = 1'b1;
				end else begin
					mem_we    = commit;
					mem_waddr = ADDR_BITS'(fill_q);
					mem_wdata = {key_q, val_q};
					nx_fill   = COUNT_BITS'(fill_q + 1'b1);
				end
			end
			CMD_ERASE: begin
				if (hit_q) begin
					// move the last pair into the hole
					nx_found  = 1'b1;
					mem_we    = commit;
					mem_waddr = slot_q;
					mem_wdata = last_q;
					nx_fill   = COUNT_BITS'(fill_q - 1'b1);
				end
			end
			CMD_CLEAR: begin
				nx_fill = '0;
			end
			CMD_LOOKUP: begin
				nx_found = hit_q;
				nx_value = hit_q ? hit_val_q : '0;
			end
			CMD_COUNT: begin
				nx_count = count_q;
			end
			default: begin
				// unknown command: fill level only
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			fill_q       <= '0;
			issue_done_q <= 1'b0;
			rd_vld_s1    <= 1'b0;
			rsp_valid_q  <= 1'b0;
		end else begin
			rd_vld_s1 <= rd_en;
			if (commit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						issue_done_q <= 1'b0;
						state_q <= (scan_cmd && (fill_q != '0)) ? ST_SCAN : ST_DONE;
					end
				end
				ST_SCAN: begin
					if (rd_en && (issue_idx_q == last_idx)) begin
						issue_done_q <= 1'b1;
					end
					if (rd_vld_s1 && (rd_idx_s1 == last_idx)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (commit) begin
						state_q <= ST_IDLE;
						fill_q  <= nx_fill;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q       <= req.cmd;
			key_q       <= req.key_in;
			val_q       <= req.value_in;
			issue_idx_q <= '0;
			hit_q       <= 1'b0;
			count_q     <= '0;
		end
		if (rd_en) begin
			rd_idx_s1   <= issue_idx_q;
			issue_idx_q <= ADDR_BITS'(issue_idx_q + 1'b1);
		end
		if (rd_vld_s1) begin
			// first matching key wins
			if ((rd_key == key_q) && !hit_q) begin
				hit_q     <= 1'b1;
				slot_q    <= rd_idx_s1;
				hit_val_q <= rd_val;
			end
			if (rd_val == val_q) begin
				count_q <= COUNT_BITS'(count_q + 1'b1);
			end
			if (rd_idx_s1 == last_idx) begin
				last_q <= rd_data;
			end
		end
		if (commit) begin
			found_q       <= nx_found;
			value_out_q   <= nx_value;
			match_count_q <= nx_count;
			level_q       <= nx_fill;
			error_q       <= nx_err;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.found       = found_q;
	assign rsp.value_out   = value_out_q;
	assign rsp.match_count = match_count_q;
	assign rsp.fill_level  = level_q;
	assign rsp.error       = error_q;

	`KVT_ASSERT_SAME(a_fill_bounded, 1'b1, fill_q <= FULL_LEVEL)
	`KVT_ASSERT_SAME(a_write_on_commit, mem_we, commit)
	`KVT_ASSERT_NEXT(a_accept_leaves_idle, accept, state_q != ST_IDLE)
	`KVT_ASSERT_SAME(a_rsp_from_done, $rose(rsp_valid_q), $past(state_q) == ST_DONE)
	`KVT_ASSERT_NEXT(a_insert_grows, commit && (cmd_q == CMD_INSERT) && !nx_err,
		fill_q == COUNT_BITS'($past(fill_q) + 1'b1))

endmodule

`default_nettype wire

### sim/testbench.sv
`default_nettype none

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import kvt_pkg::*;

	localparam int DEPTH = TABLE_DEPTH_DEF;
	localparam int KEY_W = KEY_BITS_DEF;
	localparam int VAL_W = VALUE_BITS_DEF;
	localparam int CNT_W = COUNT_BITS_DEF;

	// codes the block treats as no operation
	localparam logic [2:0] CMD_NOP_FIRST = 3'd5;
	localparam logic [2:0] CMD_NOP_LAST  = 3'd7;

	localparam int ITEM_GOAL   = 1500;  // real commands in the random part
	localparam int POOL_KEYS   = 64;    // more keys than slots, so the table can fill
	localparam int POOL_VALUES = 8;     // few values, so counts see several matches
	localparam int QUIET_LIMIT = 2000;  // cycles with no handshake before giving up
	localparam int DRAIN_CYCLES = 60;   // a full scan plus margin

	typedef struct packed {
		logic [2:0]       cmd;
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] value;
	} table_cmd_t;

	typedef struct packed {
		logic             found;
		logic [VAL_W-1:0] value_out;
		logic [CNT_W-1:0] match_count;
		logic [CNT_W-1:0] fill_level;
		logic             error;
	} table_result_t;

	logic clk = 1'b0;
	logic arst_n;

	kvt_req_if req_ch ();
	kvt_rsp_if rsp_ch ();

	keyed_value_table_top u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	always #2 clk = ~clk;

	// commands waiting to be sent, and results predicted but not yet seen
	table_cmd_t    cmd_queue[$];
	table_result_t expected_results[$];

	// shadow of the table contents as the block should hold them
	logic [KEY_W-1:0] shadow_keys[DEPTH];
	logic [VAL_W-1:0] shadow_values[DEPTH];
	int               shadow_fill = 0;

	// stimulus pools
	logic [KEY_W-1:0] key_pool[POOL_KEYS];
	logic [VAL_W-1:0] value_pool[POOL_VALUES];
	int               goal_count = 0;

	// run statistics
	int n_insert = 0, n_refused = 0, n_full_refused = 0, n_erase = 0, n_lookup = 0;
	int n_count = 0, n_clear = 0, n_nop = 0, n_hits = 0, peak_fill = 0;
	int n_results = 0, mismatches = 0, unexpected = 0;

	// idle control, each side with its own stretches of back-to-back traffic
	int send_gap = 0, sink_stall = 0, quiet_cycles = 0;
	bit send_calm = 1'b0, sink_calm = 1'b0;

	// work out the result of one command and update the shadow table
	function automatic table_result_t table_predict(table_cmd_t c);
		table_result_t r;
		int slot;
		int i;
		r = '0;
		slot = -1;
		for (i = 0; i < shadow_fill; i++)
			if (slot < 0 && shadow_keys[i] == c.key)
				slot = i;
		case (c.cmd)
			CMD_INSERT: begin
				if (shadow_fill >= DEPTH || slot >= 0) begin
					r.error = 1'b1;
				end else begin
					shadow_keys[shadow_fill]   = c.key;
					shadow_values[shadow_fill] = c.value;
					shadow_fill++;
				end
			end
			CMD_ERASE: begin
				// last pair moves into the hole
				if (slot >= 0) begin
					r.found = 1'b1;
					shadow_fill--;
					shadow_keys[slot]   = shadow_keys[shadow_fill];
					shadow_values[slot] = shadow_values[shadow_fill];
				end
			end
			CMD_CLEAR: shadow_fill = 0;
			CMD_LOOKUP: begin
				if (slot >= 0) begin
					r.found     = 1'b1;
					r.value_out = shadow_values[slot];
				end
			end
			CMD_COUNT: begin
				for (i = 0; i < shadow_fill; i++)
					if (shadow_values[i] == c.value)
						r.match_count++;
			end
			default: ;
		endcase
		r.fill_level = CNT_W'(shadow_fill);
		return r;
	endfunction

	function automatic int draw_wait(bit calm);
		return calm ? 0 : $urandom_range(0, 4);
	endfunction

	// mostly pool keys so that searches hit, now and then any key or an extreme
	function automatic logic [KEY_W-1:0] pick_key();
		int r;
		r = $urandom_range(0, 99);
		if (r < 85)
			return key_pool[$urandom_range(0, POOL_KEYS-1)];
		else if (r < 95)
			return KEY_W'($urandom_range(0, (1 << KEY_W) - 1));
		else
			return r[0] ? '1 : '0;
	endfunction

	function automatic logic [VAL_W-1:0] pick_value();
		if ($urandom_range(0, 99) < 60)
			return value_pool[$urandom_range(0, POOL_VALUES-1)];
		return $urandom;
	endfunction

	task automatic push_cmd(logic [2:0] cmd, logic [KEY_W-1:0] key, logic [VAL_W-1:0] value);
		table_cmd_t c;
		c.cmd = cmd;
		c.key = key;
		c.value = value;
		cmd_queue.push_back(c);
		if (cmd <= CMD_COUNT)
			goal_count++;
	endtask

	// driver: one item offered at a time, held until taken, random gap after it
	always @(posedge clk) begin
		table_cmd_t    c;
		table_result_t r;
		bit            holding;
		if (!arst_n) begin
			req_ch.valid    <= 1'b0;
			req_ch.cmd      <= CMD_INSERT;
			req_ch.key_in   <= '0;
			req_ch.value_in <= '0;
		end else begin
			holding = req_ch.valid && !req_ch.ready;
			if (req_ch.valid && req_ch.ready) begin
				// item taken: predict its result now, in acceptance order
				c.cmd   = req_ch.cmd;
				c.key   = req_ch.key_in;
				c.value = req_ch.value_in;
				if (c.cmd == CMD_INSERT && shadow_fill == DEPTH)
					n_full_refused++;
				r = table_predict(c);
				expected_results.push_back(r);
				case (c.cmd)
					CMD_INSERT: n_insert++;
					CMD_ERASE:  n_erase++;
					CMD_CLEAR:  n_clear++;
					CMD_LOOKUP: n_lookup++;
					CMD_COUNT:  n_count++;
					default:    n_nop++;
				endcase
				if (r.error)
					n_refused++;
				if (r.found)
					n_hits++;
				if (shadow_fill > peak_fill)
					peak_fill = shadow_fill;
				if ($urandom_range(0, 99) == 0)
					send_calm = !send_calm;
			end
			if (!holding) begin
				if (send_gap > 0) begin
					send_gap--;
					req_ch.valid <= 1'b0;
				end else if (cmd_queue.size() > 0) begin
					c = cmd_queue.pop_front();
					req_ch.cmd      <= c.cmd;
					req_ch.key_in   <= c.key;
					req_ch.value_in <= c.value;
					req_ch.valid    <= 1'b1;
					send_gap = draw_wait(send_calm);
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// monitor: take results, compare each field with the oldest prediction
	always @(posedge clk) begin
		table_result_t got, want;
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				got.found       = rsp_ch.found;
				got.value_out   = rsp_ch.value_out;
				got.match_count = rsp_ch.match_count;
				got.fill_level  = rsp_ch.fill_level;
				got.error       = rsp_ch.error;
				if (expected_results.size() == 0) begin
					unexpected++;
					if (mismatches + unexpected <= 10)
						$display("result %0d arrived with nothing expected", n_results);
				end else begin
					want = expected_results.pop_front();
					if (got.found !== want.found || got.value_out !== want.value_out
							|| got.match_count !== want.match_count
							|| got.fill_level !== want.fill_level
							|| got.error !== want.error) begin
						mismatches++;
						if (mismatches + unexpected <= 10) begin
							$display("result %0d: expected found=%0d value=%h count=%0d fill=%0d err=%0d",
								n_results, want.found, want.value_out, want.match_count,
								want.fill_level, want.error);
							$display("  got found=%0d value=%h count=%0d fill=%0d err=%0d",
								got.found, got.value_out, got.match_count,
								got.fill_level, got.error);
						end
					end
				end
				n_results++;
				if ($urandom_range(0, 99) == 0)
					sink_calm = !sink_calm;
				sink_stall = draw_wait(sink_calm);
			end else if (sink_stall > 0 && rsp_ch.valid) begin
				// stall only counts down while a result is waiting
				sink_stall--;
			end
			rsp_ch.ready <= (sink_stall == 0);
		end
	end

	// watchdog: too long without any useful handshake means the block hung
	always @(posedge clk) begin
		if (!arst_n || (req_ch.valid && req_ch.ready)
				|| (rsp_ch.valid && rsp_ch.ready && expected_results.size() != 0)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("no handshake for %0d cycles", QUIET_LIMIT);
			$display("[keyed_value_table_top] ERROR");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		int i;
		int base;
		int r;
		int len;

		// known values on every input from time zero
		arst_n          = 1'b0;
		req_ch.valid    = 1'b0;
		req_ch.cmd      = CMD_INSERT;
		req_ch.key_in   = '0;
		req_ch.value_in = '0;
		rsp_ch.ready    = 1'b0;

		for (i = 0; i < POOL_KEYS; i++)
			key_pool[i] = KEY_W'($urandom_range(0, (1 << KEY_W) - 1));
		key_pool[0] = '0;
		key_pool[1] = '1;
		for (i = 0; i < POOL_VALUES; i++)
			value_pool[i] = $urandom;
		value_pool[0] = '0;
		value_pool[1] = '1;

		// directed: empty table, extremes, duplicates, erase, unknown codes, clear
		push_cmd(CMD_LOOKUP, '0, '0);           // lookup on empty table
		push_cmd(CMD_ERASE, '0, '1);            // erase of absent key
		push_cmd(CMD_COUNT, '0, '0);            // count on empty table
		push_cmd(CMD_INSERT, '0, '0);
		push_cmd(CMD_INSERT, '1, '1);
		push_cmd(CMD_INSERT, '1, 32'd1);        // duplicate key refused
		push_cmd(CMD_LOOKUP, '1, '0);
		push_cmd(CMD_LOOKUP, '0, '1);
		push_cmd(CMD_COUNT, '1, '1);
		push_cmd(CMD_COUNT, '1, '0);
		push_cmd(CMD_INSERT, 16'h0001, '1);
		push_cmd(CMD_COUNT, '0, '1);            // two matching values
		push_cmd(CMD_ERASE, '0, '0);            // hole at slot zero, last pair moves in
		push_cmd(CMD_LOOKUP, 16'h0001, '0);
		push_cmd(CMD_ERASE, '0, '0);            // already gone
		for (r = int'(CMD_NOP_FIRST); r <= int'(CMD_NOP_LAST); r++)
			push_cmd(r[2:0], '1, '1);
		push_cmd(CMD_CLEAR, '1, '1);
		push_cmd(CMD_LOOKUP, '1, '0);           // stale contents must not be found
		push_cmd(CMD_COUNT, '0, '1);
		push_cmd(CMD_INSERT, 16'h5555, 32'hAAAA_AAAA);
		push_cmd(CMD_LOOKUP, 16'h5555, '0);
		goal_count = 0;

		// random part built from short sequences of different flavors
		while (goal_count < ITEM_GOAL) begin
			case ($urandom_range(0, 5))
				0: begin
					// fill past capacity with distinct keys, then probe
					push_cmd(CMD_CLEAR, pick_key(), pick_value());
					base = $urandom_range(0, POOL_KEYS-1);
					for (i = 0; i < DEPTH + 2; i++)
						push_cmd(CMD_INSERT, key_pool[(base + i) % POOL_KEYS], pick_value());
					push_cmd(CMD_INSERT, key_pool[(base + DEPTH + 3) % POOL_KEYS], pick_value());
					repeat (3) push_cmd(CMD_LOOKUP, pick_key(), pick_value());
					repeat (2) push_cmd(CMD_COUNT, pick_key(), pick_value());
				end
				1: begin
					// drain, mostly erases
					len = $urandom_range(10, 30);
					repeat (len) begin
						if ($urandom_range(0, 99) < 70)
							push_cmd(CMD_ERASE, pick_key(), pick_value());
						else
							push_cmd(CMD_LOOKUP, pick_key(), pick_value());
					end
				end
				default: begin
					// mixed traffic with a few unknown codes
					len = $urandom_range(15, 40);
					repeat (len) begin
						r = $urandom_range(0, 99);
						if (r < 35)
							push_cmd(CMD_INSERT, pick_key(), pick_value());
						else if (r < 60)
							push_cmd(CMD_ERASE, pick_key(), pick_value());
						else if (r < 79)
							push_cmd(CMD_LOOKUP, pick_key(), pick_value());
						else if (r < 95)
							push_cmd(CMD_COUNT, pick_key(), pick_value());
						else if (r < 96)
							push_cmd(CMD_CLEAR, pick_key(), pick_value());
						else
							push_cmd(3'($urandom_range(CMD_NOP_FIRST, CMD_NOP_LAST)),
								pick_key(), pick_value());
					end
				end
			endcase
		end

		// single reset, released on a rising edge
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// wait until everything is sent and every result is back
		@(negedge clk);
		while (cmd_queue.size() != 0 || req_ch.valid || expected_results.size() != 0)
			@(negedge clk);
		// watch for stray results a while longer
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);

		$write("ran %0d inserts (%0d refused, %0d on a full table), %0d erases, ",
			n_insert, n_refused, n_full_refused, n_erase);
		$display("%0d lookups, %0d counts, %0d clears, %0d unknown codes",
			n_lookup, n_count, n_clear, n_nop);
		$write("%0d searches hit, fill peaked at %0d, %0d results checked, ",
			n_hits, peak_fill, n_results);
		$display("%0d mismatches, %0d unexpected, %0d missing",
			mismatches, unexpected, expected_results.size());
		if (mismatches == 0 && unexpected == 0 && expected_results.size() == 0) begin
			$display("[keyed_value_table_top] OK");
		end else begin
			$display("[keyed_value_table_top] ERROR");
		end
		$finish;
	end

endmodule

`default_nettype wire
